@@ src/address_range_lookup_table_defines.svh @@
// assertion macros for the address range lookup table sources, included by arlt_dp
// no dependencies; define SYNTH to drop the checks
`ifndef ADDRESS_RANGE_LOOKUP_TABLE_DEFINES_SVH
`define ADDRESS_RANGE_LOOKUP_TABLE_DEFINES_SVH

`ifndef SYNTH
`define ARLT_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("arlt check failed");
`define ARLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arlt check failed");
`define ARLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arlt check failed");
`else
`define ARLT_ASSERT(label, clk, rst, expr)
`define ARLT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ARLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/arlt_pkg.sv @@
// shared types, codes and defaults for the address range lookup table
// no dependencies
package arlt_pkg;

  localparam int MAX_REGIONS_DEF = 256;
  localparam int ID_BITS_DEF     = 16;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 32;
  localparam int RID_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  byte_length;
    logic [RID_W-1:0]  region_id;
    logic [ADDR_W-1:0] query_address;
  } arlt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RID_W-1:0]    found_id;
    logic [ADDR_W-1:0]   found_start;
    logic                at_region_start;
    logic [COUNT_W-1:0]  entry_count;
  } arlt_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LOOK_CMP,
    S_RESP
  } arlt_state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_MISS,
    RES_LOOK
  } arlt_res_t;

  typedef struct packed {
    logic      capture;
    logic      clear_count;
    logic      srch_init;
    logic      srch_rd;
    logic      srch_step;
    logic      shift_init;
    logic      shift_rd;
    logic      shift_wr;
    logic      place;
    logic      look_rd;
    arlt_res_t res_sel;
    logic      load_out;
  } arlt_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             srch_done;
    logic             shift_done;
    logic             ub_zero;
    logic             out_busy;
  } arlt_sts_t;

endpackage

@@ src/arlt_stream_if.sv @@
// valid/ready stream channel carrying one payload of type T
// no dependencies
interface arlt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/address_range_lookup_table.sv @@
// Address range lookup table: a sorted table of code regions (start, length, id).
// Requests arrive on req (valid/ready) and carry a cmd: clear, insert or lookup.
// Every request gives exactly one response on rsp with status, the hit region's
// id and start, an at-start flag and the number of regions held afterwards.
// Requests are handled one at a time; inserts and lookups run a binary search over
// the region memory (one read port, registered read data), while clear and unused
// codes answer without a search, as do full-table inserts, leaving the table as is.
// Inserts shift the entries above the slot up one at a time.
// A new request is accepted while the last response still waits in the output
// register; a stalled receiver holds the response and the next request then
// waits at its end until the register is taken.
// Synchronous active-high reset empties the table at once; the region memory
// itself is not cleared, as only entries below the count are ever read.
// depends on arlt_pkg, arlt_stream_if, arlt_ctrl and arlt_dp
module address_range_lookup_table #(
  parameter int MAX_REGIONS = arlt_pkg::MAX_REGIONS_DEF,
  parameter int ID_BITS     = arlt_pkg::ID_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  arlt_stream_if.sink   req,
  arlt_stream_if.source rsp
);
  import arlt_pkg::*;

  arlt_cmd_t cmd;
  arlt_sts_t sts;
  arlt_req_t req_data;
  arlt_rsp_t rsp_data;
  logic      req_ready;
  logic      rsp_valid;

  assign req_data  = req.data;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  arlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arlt_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

endmodule

@@ src/arlt_ctrl.sv @@
// sequencer for clear, insert and lookup requests
// depends on arlt_pkg
module arlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  arlt_pkg::arlt_sts_t sts,
  output arlt_pkg::arlt_cmd_t cmd
);
  import arlt_pkg::*;

  arlt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no request is taken while reset is held
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd.res_sel     = RES_OK;
            state_next      = S_RESP;
          end
          CMD_INSERT: begin
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
              state_next  = S_RESP;
            end else begin
              cmd.srch_init = 1'b1;
              state_next    = S_SRCH_RD;
            end
          end
          CMD_LOOKUP: begin
            cmd.srch_init = 1'b1;
            state_next    = S_SRCH_RD;
          end
          default: begin
            cmd.res_sel = RES_OK;
            state_next  = S_RESP;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (!sts.srch_done) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_SRCH_CMP;
        end else if (sts.cmd == CMD_INSERT) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_RD;
        end else if (sts.ub_zero) begin
          cmd.res_sel = RES_MISS;
          state_next  = S_RESP;
        end else begin
          cmd.look_rd = 1'b1;
          state_next  = S_LOOK_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH_RD;
      end
      S_SHIFT_RD: begin
        // open a slot at the insertion point, top entry first
        if (sts.shift_done) begin
          cmd.place   = 1'b1;
          cmd.res_sel = RES_OK;
          state_next  = S_RESP;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_LOOK_CMP: begin
        cmd.res_sel = RES_LOOK;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/arlt_dp.sv @@
// region memory, binary search bounds, shift pointer and result register
// depends on arlt_pkg and the assertion macro header
`include "address_range_lookup_table_defines.svh"

module arlt_dp #(
  parameter int MAX_REGIONS = arlt_pkg::MAX_REGIONS_DEF,
  parameter int ID_BITS     = arlt_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  arlt_pkg::arlt_req_t req_data,
  input  arlt_pkg::arlt_cmd_t cmd,
  output arlt_pkg::arlt_sts_t sts,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output arlt_pkg::arlt_rsp_t rsp_data
);
  import arlt_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = $clog2(MAX_REGIONS);

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    logic [ID_BITS-1:0] id;
  } entry_t;

  entry_t mem [MAX_REGIONS];
  entry_t rdata;
  entry_t new_entry;
  entry_t wr_data;

  arlt_req_t req_q;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [IDX_W-1:0]  k;
  logic [CNT_W:0]    sum;
  logic [IDX_W-1:0]  mid;
  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] offset;
  logic              hit;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  logic [STATUS_W-1:0] res_status;
  logic [ID_BITS-1:0]  res_id;
  logic [ADDR_W-1:0]   res_start;
  logic                res_at;

  // search key: inserts look for the slot after all starts not above the new one
  assign key = (req_q.cmd == CMD_INSERT) ? req_q.start_address : req_q.query_address;
  assign sum = {1'b0, lo} + {1'b0, hi};
  assign mid = sum[IDX_W:1];

  assign offset    = req_q.query_address - rdata.start;
  assign hit       = offset < rdata.len;
  assign new_entry = '{start: req_q.start_address, len: req_q.byte_length,
                       id: ID_BITS'(req_q.region_id)};

  always_comb begin
    rd_en = cmd.srch_rd | cmd.shift_rd | cmd.look_rd;
    if (cmd.shift_rd) begin
      rd_addr = k - IDX_W'(1);
    end else if (cmd.look_rd) begin
      rd_addr = IDX_W'(lo - CNT_W'(1));
    end else begin
      rd_addr = mid;
    end
    wr_en = cmd.shift_wr | cmd.place;
    if (cmd.place) begin
      wr_addr = IDX_W'(lo);
      wr_data = new_entry;
    end else begin
      wr_addr = k;
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lo    <= '0;
      hi    <= '0;
      k     <= '0;
    end else begin
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.place) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.srch_init) begin
        lo <= '0;
        hi <= count;
      end else if (cmd.srch_step) begin
        if (rdata.start <= key) begin
          lo <= CNT_W'(mid) + CNT_W'(1);
        end else begin
          hi <= CNT_W'(mid);
        end
      end
      if (cmd.shift_init) begin
        k <= IDX_W'(count);
      end else if (cmd.shift_wr) begin
        k <= k - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_sel) inside
      RES_OK, RES_FULL, RES_MISS: begin
        res_status <= (cmd.res_sel == RES_OK) ? ST_OK :
                      (cmd.res_sel == RES_FULL) ? ST_FULL : ST_MISS;
        res_id     <= '0;
        res_start  <= '0;
        res_at     <= 1'b0;
      end
      RES_LOOK: begin
        if (hit) begin
          res_status <= ST_OK;
          res_id     <= rdata.id;
          res_start  <= rdata.start;
          res_at     <= (req_q.query_address == rdata.start);
        end else begin
          res_status <= ST_MISS;
          res_id     <= '0;
          res_start  <= '0;
          res_at     <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.status          <= res_status;
      rsp_data.found_id        <= RID_W'(res_id);
      rsp_data.found_start     <= res_start;
      rsp_data.at_region_start <= res_at;
      rsp_data.entry_count     <= COUNT_W'(count);
    end
  end

  always_comb begin
    sts.cmd        = req_q.cmd;
    sts.full       = (count == CNT_W'(MAX_REGIONS));
    sts.srch_done  = (lo == hi);
    sts.shift_done = (CNT_W'(k) == lo);
    sts.ub_zero    = (lo == '0);
    sts.out_busy   = rsp_valid & ~rsp_ready;
  end

  `ARLT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_REGIONS))
  `ARLT_ASSERT_IMPL(a_place_room, clk, rst, cmd.place, count < CNT_W'(MAX_REGIONS))
  `ARLT_ASSERT_NEXT(a_place_grows, clk, rst, cmd.place, count == $past(count) + CNT_W'(1))
  `ARLT_ASSERT_IMPL(a_search_open, clk, rst, cmd.srch_step, lo < hi)
  `ARLT_ASSERT_IMPL(a_no_overrun, clk, rst, cmd.load_out, !(rsp_valid && !rsp_ready))

endmodule

@@ tb/sv/tb_address_range_lookup_table.sv @@
// self-checking testbench for address_range_lookup_table: clear, insert and lookup requests
// go in on a valid/ready channel and every response is checked against a sorted-table model
// depends on arlt_pkg, arlt_stream_if and the address_range_lookup_table rtl
`timescale 1ns / 100ps

module tb_address_range_lookup_table;
  import arlt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arlt_stream_if #(.T(arlt_req_t)) req_if ();
  arlt_stream_if #(.T(arlt_rsp_t)) rsp_if ();

  address_range_lookup_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #10 clk = ~clk;

  // model copy of the region table, kept sorted by start
  logic [ADDR_W-1:0] region_start [MAX_REGIONS_DEF];
  logic [LEN_W-1:0]  region_len   [MAX_REGIONS_DEF];
  logic [RID_W-1:0]  region_tag   [MAX_REGIONS_DEF];
  int unsigned       region_total = 0;

  arlt_req_t pending_requests [$];
  arlt_rsp_t awaited_responses [$];

  int unsigned accepted_requests = 0;
  int unsigned total_requests = 0;
  int unsigned checked_responses = 0;
  int unsigned fail_count = 0;
  int unsigned insert_count = 0;
  int unsigned full_drops = 0;
  int unsigned lookup_count = 0;
  int unsigned lookup_hits = 0;
  logic        quiet_stretch;

  // no idling on either side for a while in the middle of the run
  assign quiet_stretch = (accepted_requests >= 700) && (accepted_requests < 1000);

  function automatic arlt_rsp_t predict_region_response(input arlt_req_t r);
    arlt_rsp_t   o;
    int unsigned pos;
    int unsigned k;
    int          sel;
    logic [ADDR_W-1:0] offset;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_CLEAR: begin
        region_total = 0;
      end
      CMD_INSERT: begin
        insert_count++;
        if (region_total >= MAX_REGIONS_DEF) begin
          o.status = ST_FULL;
          full_drops++;
        end else begin
          // new region goes after every start at or below its own
          pos = 0;
          while (pos < region_total && region_start[pos] <= r.start_address) pos++;
          for (k = region_total; k > pos; k--) begin
            region_start[k] = region_start[k-1];
            region_len[k]   = region_len[k-1];
            region_tag[k]   = region_tag[k-1];
          end
          region_start[pos] = r.start_address;
          region_len[pos]   = r.byte_length;
          region_tag[pos]   = r.region_id;
          region_total++;
        end
      end
      CMD_LOOKUP: begin
        lookup_count++;
        sel = -1;
        for (k = 0; k < region_total; k++) begin
          if (region_start[k] <= r.query_address) sel = int'(k);
        end
        if (sel >= 0) offset = r.query_address - region_start[sel];
        // wrapped offset below length means inside, with no wrap past the top
        if (sel >= 0 && offset < region_len[sel]) begin
          o.found_id        = region_tag[sel];
          o.found_start     = region_start[sel];
          o.at_region_start = (r.query_address == region_start[sel]);
          lookup_hits++;
        end else begin
          o.status = ST_MISS;
        end
      end
      default: begin
      end
    endcase
    o.entry_count = COUNT_W'(region_total);
    return o;
  endfunction

  task automatic queue_req(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] s,
                           input logic [LEN_W-1:0] l, input logic [RID_W-1:0] id,
                           input logic [ADDR_W-1:0] q);
    arlt_req_t r;
    r.cmd           = c;
    r.start_address = s;
    r.byte_length   = l;
    r.region_id     = id;
    r.query_address = q;
    pending_requests.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_responses.push_back(predict_region_response(req_if.data));
        accepted_requests++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 8)) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_requests.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : rsp_monitor
    arlt_rsp_t want;
    arlt_rsp_t got;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (awaited_responses.size() == 0) begin
          $error("response with nothing awaited: status %0d id %0h", got.status, got.found_id);
          fail_count++;
        end else begin
          want = awaited_responses.pop_front();
          checked_responses++;
          if (got.status !== want.status) begin
            $error("status: expected %0d got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.found_id !== want.found_id) begin
            $error("found_id: expected %0h got %0h", want.found_id, got.found_id);
            fail_count++;
          end
          if (got.found_start !== want.found_start) begin
            $error("found_start: expected %0h got %0h", want.found_start, got.found_start);
            fail_count++;
          end
          if (got.at_region_start !== want.at_region_start) begin
            $error("at_region_start: expected %0b got %0b", want.at_region_start,
                   got.at_region_start);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin
    logic [ADDR_W-1:0] known_start [$];
    logic [LEN_W-1:0]  known_len [$];
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] spread;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] q;
    logic [LEN_W-1:0]  l;
    int unsigned       n_ops;
    int unsigned       pick;
    int unsigned       k;
    bit                big_fill;
    bit                filled_once;

    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;

    // directed: boundaries, equal starts, wrap at the top, zero length, unused code, clear
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_0000);
    queue_req(CMD_INSERT, 32'h0000_1000, 32'h0000_0100, 16'h0001, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1000);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_10ff);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1100);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_0fff);
    queue_req(CMD_INSERT, 32'h0000_1000, 32'h0000_0010, 16'hffff, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1008);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1050);
    queue_req(CMD_INSERT, 32'hffff_ff00, 32'hffff_ffff, 16'ha5a5, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'hffff_ffff);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_0000);
    queue_req(CMD_INSERT, 32'h0000_2000, 32'h0000_0000, 16'h5a5a, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_2000);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_3000);
    queue_req(CMD_INSERT, 32'h0000_0000, 32'h8000_0000, 16'h8000, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_0000);
    queue_req(CMD_INSERT, 32'hffff_ffff, 32'h0000_0001, 16'h0000, 32'h0);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'hffff_ffff);
    queue_req(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1000);
    queue_req(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    queue_req(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0000_1000);

    // random phases: clustered regions, lookups aimed at their edges, one fill to capacity
    filled_once = 1'b0;
    while (pending_requests.size() < 1470) begin
      big_fill = !filled_once && pending_requests.size() > 400;
      base     = $urandom;
      spread   = big_fill ? 32'h0010_0000 : (32'h1 << $urandom_range(4, 20));
      if (big_fill || $urandom_range(0, 3) != 0) begin
        queue_req(CMD_CLEAR, $urandom, $urandom, RID_W'($urandom_range(0, 65535)), $urandom);
        known_start.delete();
        known_len.delete();
      end
      n_ops = big_fill ? 300 : $urandom_range(10, 60);
      for (int unsigned i = 0; i < n_ops; i++) begin
        pick = $urandom_range(0, 99);
        if (big_fill ? (i < 259) : (pick < 40)) begin
          pick = $urandom_range(0, 99);
          if (known_start.size() > 0 && pick < 15)
            s = known_start[$urandom_range(0, known_start.size() - 1)];
          else if (pick < 18)
            s = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
          else
            s = base + $urandom_range(0, spread);
          pick = $urandom_range(0, 99);
          if (pick < 6)
            l = '0;
          else if (pick < 12)
            l = $urandom;
          else
            l = $urandom_range(1, spread / 8 + 1);
          known_start.push_back(s);
          known_len.push_back(l);
          queue_req(CMD_INSERT, s, l, RID_W'($urandom_range(0, 65535)), $urandom);
        end else if (big_fill || pick < 95) begin
          if (known_start.size() > 0 && $urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, known_start.size() - 1);
            case ($urandom_range(0, 5))
              0: q = known_start[k];
              1: q = known_start[k] + known_len[k] - 1;
              2: q = known_start[k] + known_len[k];
              3: q = known_start[k] - 1;
              4: q = known_start[k] + $urandom_range(0, known_len[k]);
              default: q = base + $urandom_range(0, spread);
            endcase
          end else begin
            q = $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, spread);
          end
          queue_req(CMD_LOOKUP, $urandom, $urandom, RID_W'($urandom_range(0, 65535)), q);
        end else if (pick < 98) begin
          queue_req(CMD_CLEAR, $urandom, $urandom, RID_W'($urandom_range(0, 65535)), $urandom);
          known_start.delete();
          known_len.delete();
        end else begin
          queue_req(CMD_UNUSED, $urandom, $urandom, RID_W'($urandom_range(0, 65535)), $urandom);
        end
      end
      if (big_fill) filled_once = 1'b1;
    end
    total_requests = pending_requests.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_requests < total_requests || awaited_responses.size() > 0)
      @(posedge clk);
    // catch any stray response after the last awaited one
    repeat (50) @(posedge clk);

    $display("%0d requests: %0d inserts (%0d dropped on a full table), %0d lookups (%0d hits)",
             total_requests, insert_count, full_drops, lookup_count, lookup_hits);
    $display("%0d responses checked, %0d mismatches", checked_responses, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
